[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the bd2_average module.
// ----------------------------------------------------------------------------
// Both macros expect a clock named aclk; BD2_ASSERT also needs aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BD2_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bd2 assertion failed");

// Checked on every edge, reset included.
`define BD2_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bd2 assertion failed");

`endif

[hdl/bd2_pkg.sv]
// ----------------------------------------------------------------------------
// bd2_pkg
// Types, constants and channel arithmetic shared by the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bd2_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    localparam int DIM_W      = 11;
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = PIX_W / CHAN_W;
    localparam int PSUM_W     = CHAN_W + 1;
    localparam int LINE_W     = NUM_CHAN * PSUM_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIM_W-1:0] MIN_DIM     = DIM_W'(2);
    localparam logic [DIM_W-1:0] MAX_W_DIM   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM   = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_DIM   = DIM_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1
    } cfg_index_t;

    typedef logic [LINE_W-1:0] line_word_t;

    // One pending output: pair sum of the current row plus the frame-end mark.
    typedef struct packed {
        line_word_t here_sum;
        logic       frame_last;
    } avg_req_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Largest odd index below an even-rounded size.
    function automatic logic [DIM_W-1:0] last_odd(input logic [DIM_W-1:0] v);
        return {v[DIM_W-1:1], 1'b0} - DIM_W'(1);
    endfunction

    function automatic line_word_t pair_sums(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
        line_word_t r;
        r = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            r[k*PSUM_W +: PSUM_W] = PSUM_W'(a[k*CHAN_W +: CHAN_W])
                                  + PSUM_W'(b[k*CHAN_W +: CHAN_W]);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] round_avg(input line_word_t above,
                                                   input line_word_t here);
        logic [PIX_W-1:0]  r;
        logic [PSUM_W+1:0] s;
        r = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            s = (PSUM_W+2)'(above[k*PSUM_W +: PSUM_W])
              + (PSUM_W+2)'(here[k*PSUM_W +: PSUM_W])
              + (PSUM_W+2)'(2);
            r[k*CHAN_W +: CHAN_W] = s[CHAN_W+1:2];
        end
        return r;
    endfunction

endpackage

[hdl/box_downsample_2x2_argb_core.sv]
// ----------------------------------------------------------------------------
// box_downsample_2x2_argb_core
// 2x2 box-filter downsampler for raster ARGB streams, one mip level.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  s_*      | in        | one source pixel, raster order
//  m_*      | out       | one averaged pixel, tlast on the frame's final one
//  cfg_*    | in        | register write: 0 src_width, 1 src_height
//
//  One source pixel per cycle, sustained while the output is not stalled;
//  the line store has one write and one read port, and each pixel uses at
//  most one of them. An output is formed from the odd-row, odd-column pixel
//  that completes its block: line-store read, then the output register.
//  Reset clears counters, sizes (512x512) and the pipeline; the line store
//  is not cleared: every entry read is written on the row above first.
//  A stalled output register backs up one stage, then drops s_tready.
// ----------------------------------------------------------------------------
module box_downsample_2x2_argb_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] pixel_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] pixel_out
    output logic        m_tlast,     // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int DW = bd2_pkg::DIM_W;
    localparam int AW = bd2_pkg::ADDR_W;

    logic [DW-1:0]             width_reg, height_reg;
    logic [DW-1:0]             last_col_reg, last_row_reg;
    logic [DW-1:0]             col_reg, col_next;
    logic [DW-1:0]             row_reg, row_next;
    logic [bd2_pkg::PIX_W-1:0] held_reg;
    logic [DW-1:0]             cfg_clamped;

    logic                      accept;
    logic                      in_frame;
    logic                      pair_done;
    logic                      line_wr;
    logic                      line_rd;
    logic [AW-1:0]             slot;
    bd2_pkg::line_word_t       here_sum;
    bd2_pkg::line_word_t       above_sum;
    bd2_pkg::avg_req_t         req;
    logic                      req_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        case (bd2_pkg::cfg_index_t'(cfg_index))
            bd2_pkg::CFG_SRC_WIDTH:  cfg_clamped = bd2_pkg::clamp_dim(cfg_data,
                                                                    bd2_pkg::MAX_W_DIM);
            bd2_pkg::CFG_SRC_HEIGHT: cfg_clamped = bd2_pkg::clamp_dim(cfg_data,
                                                                    bd2_pkg::MAX_H_DIM);
            default:                 cfg_clamped = cfg_data;
        endcase
    end

    // Sizes are kept in clamped form, with the last block position derived once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= bd2_pkg::RESET_DIM;
            height_reg   <= bd2_pkg::RESET_DIM;
            last_col_reg <= bd2_pkg::last_odd(bd2_pkg::RESET_DIM);
            last_row_reg <= bd2_pkg::last_odd(bd2_pkg::RESET_DIM);
        end else if (cfg_valid && cfg_ready) begin
            case (bd2_pkg::cfg_index_t'(cfg_index))
                bd2_pkg::CFG_SRC_WIDTH: begin
                    width_reg    <= cfg_clamped;
                    last_col_reg <= bd2_pkg::last_odd(cfg_clamped);
                end
                bd2_pkg::CFG_SRC_HEIGHT: begin
                    height_reg   <= cfg_clamped;
                    last_row_reg <= bd2_pkg::last_odd(cfg_clamped);
                end
                default: ;
            endcase
        end
    end

    assign s_tready  = req_ready;
    assign accept    = s_tvalid && s_tready;
    assign in_frame  = (col_reg < width_reg) && (row_reg < height_reg);
    assign pair_done = in_frame && col_reg[0];
    assign slot      = col_reg[AW:1];
    assign here_sum  = bd2_pkg::pair_sums(held_reg, s_tdata);

    // Even rows store the pair sum; odd rows read it back for the block.
    assign line_wr = accept && pair_done && !row_reg[0];
    assign line_rd = accept && pair_done && row_reg[0];

    assign req.here_sum   = here_sum;
    assign req.frame_last = (row_reg == last_row_reg) && (col_reg == last_col_reg);

    always_comb begin
        col_next = col_reg + DW'(1);
        row_next = row_reg;
        if (col_next >= width_reg) begin
            col_next = '0;
            row_next = row_reg + DW'(1);
            if (row_next >= height_reg) begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_frame && !col_reg[0]) begin
                held_reg <= s_tdata;
            end
        end
    end

    bd2_line_ram #(
        .DEPTH (bd2_pkg::LINE_DEPTH),
        .WIDTH (bd2_pkg::LINE_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_wr),
        .wr_addr (slot),
        .wr_data (here_sum),
        .rd_en   (line_rd),
        .rd_addr (slot),
        .rd_data (above_sum)
    );

    bd2_average u_average (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (line_rd),
        .req_ready (req_ready),
        .req       (req),
        .above_sum (above_sum),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[hdl/bd2_line_ram.sv]
// ----------------------------------------------------------------------------
// bd2_line_ram
// Simple dual-port line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bd2_line_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 36
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bd2_average.sv]
// ----------------------------------------------------------------------------
// bd2_average
// Joins the line-store word with the current pair sum, rounds, and holds the
// result in the output register until the downstream takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bd2_average (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  bd2_pkg::avg_req_t      req,
    input  bd2_pkg::line_word_t    above_sum,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [31:0] pixel_out
    output logic                   m_tlast    // frame_last
);

    logic                      s1_valid_reg, s1_valid_next;
    bd2_pkg::avg_req_t         s1_req_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [bd2_pkg::PIX_W-1:0] out_pixel_reg;
    logic                      out_last_reg;
    logic                      out_adv;
    logic                      req_take;

    assign out_adv   = !out_valid_reg || m_tready;
    assign req_ready = !s1_valid_reg || out_adv;
    assign req_take  = req_valid && req_ready;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_adv) begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (req_take) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            s1_req_reg <= req;
        end
        if (out_adv && s1_valid_reg) begin
            out_pixel_reg <= bd2_pkg::round_avg(above_sum, s1_req_reg.here_sum);
            out_last_reg  <= s1_req_reg.frame_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

    `BD2_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !s1_valid_reg && !out_valid_reg)
    `BD2_ASSERT(a_stage_holds, s1_valid_reg && !out_adv |=> s1_valid_reg)
    `BD2_ASSERT(a_stage_moves, s1_valid_reg && out_adv |=> out_valid_reg)

endmodule
